[hw/rtl/pyse_pkg.sv]
// ----------------------------------------------------------------------------
// pyse_pkg
// Shared types, constants and the similarity test for the YUV
// similarity edge core.
// ----------------------------------------------------------------------------
`default_nettype none

package pyse_pkg;

	// fixed point conversion weights, 16 fraction bits
	localparam logic [15:0] KY_R = 16'd19595;
	localparam logic [15:0] KY_G = 16'd38470;
	localparam logic [15:0] KY_B = 16'd7471;
	localparam logic [15:0] KU   = 16'd32244;
	localparam logic [15:0] KV   = 16'd57475;

	localparam logic [12:0] HEIGHT_MAX = 13'd4096;

	// register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_LUMA_THRESHOLD = 3'd2;
	localparam logic [2:0] REG_U_THRESHOLD    = 3'd3;
	localparam logic [2:0] REG_V_THRESHOLD    = 3'd4;

	// register reset values
	localparam logic [12:0] WIDTH_RST  = 13'd64;
	localparam logic [12:0] HEIGHT_RST = 13'd64;
	localparam logic [7:0]  LUMA_RST   = 8'd48;
	localparam logic [7:0]  U_RST      = 8'd7;
	localparam logic [7:0]  V_RST      = 8'd6;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [7:0]  luma_threshold;
		logic [7:0]  u_threshold;
		logic [7:0]  v_threshold;
	} cfg_t;

	// u and v are two's complement
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [8:0] v;
	} yuv_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LUMA,
		ST_CHROMA,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic luma;
		logic chroma;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic [9:0] abs10(logic [9:0] d);
		return d[9] ? (~d + 10'd1) : d;
	endfunction

	function automatic logic is_similar(yuv_t a, yuv_t b, cfg_t c);
		logic [9:0] dy;
		logic [9:0] du;
		logic [9:0] dv;
		dy = {2'b00, a.y} - {2'b00, b.y};
		du = {{2{a.u[7]}}, a.u} - {{2{b.u[7]}}, b.u};
		dv = {a.v[8], a.v} - {b.v[8], b.v};
		return !((abs10(dy) > {2'b00, c.luma_threshold}) ||
			(abs10(du) > {2'b00, c.u_threshold}) ||
			(abs10(dv) > {2'b00, c.v_threshold}));
	endfunction

endpackage

`default_nettype wire

[hw/rtl/pyse_ctrl.sv]
// ----------------------------------------------------------------------------
// pyse_ctrl
// Sequencer for one pixel: accept, luma, chroma, then commit of the
// result beat and the line store write.
// ----------------------------------------------------------------------------
`default_nettype none

module pyse_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire pyse_pkg::status_t sts,
	output pyse_pkg::cmd_t         cmd
);
	import pyse_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LUMA;
			end
			ST_LUMA:   state_d = ST_CHROMA;
			ST_CHROMA: state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_LUMA:   cmd.luma = 1'b1;
			ST_CHROMA: cmd.chroma = 1'b1;
			ST_COMMIT: cmd.commit = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/pyse_dp.sv]
// ----------------------------------------------------------------------------
// pyse_dp
// Position counters, RGB to YUV conversion, line store, neighbor
// registers, similarity compare and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pyse_dp #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pyse_pkg::cmd_t    cmd,
	output pyse_pkg::status_t      sts,
	input  wire pyse_pkg::cfg_t    cfg,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	input  wire logic              start_of_frame,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [11:0]            column,
	output logic [11:0]            row,
	output logic                   similar_left,
	output logic                   similar_up_left,
	output logic                   similar_up,
	output logic                   similar_up_right,
	output logic                   end_of_frame
);
	import pyse_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > 13) ? CW + 1 : 13;

	// position state
	logic [CW-1:0] col_cnt_q;
	logic [11:0]   row_cnt_q;

	// item registers
	logic [7:0]    r_q, g_q, b_q, y_q;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic          has_left_q, has_up_q, has_right_q, eof_q;
	yuv_t          cur_q, up_q, ur_q, rd_q;

	// neighbor state
	yuv_t          left_q, up_left_q;

	// output register
	logic          out_valid_q;
	logic [11:0]   column_q, row_out_q;
	logic          sl_q, sul_q, su_q, sur_q, eof_out_q;

	yuv_t          mem [MAX_WIDTH];

	logic [EW-1:0] w_eff;
	logic [12:0]   h_eff;
	logic [CW-1:0] pos_col;
	logic [11:0]   pos_row;
	logic          has_right, last_row;
	logic [CW-1:0] rd_addr;
	logic [23:0]   luma_sum;
	logic [8:0]    du, dv;
	logic [7:0]    mag_u, mag_v;
	logic [23:0]   prod_u, prod_v;
	logic [7:0]    u_val;
	logic [8:0]    v_val;

	always_comb begin
		w_eff = EW'(cfg.image_width);
		if (w_eff == '0) begin
			w_eff = EW'(1);
		end else if (w_eff > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end
		h_eff = cfg.image_height;
		if (h_eff == 13'd0) begin
			h_eff = 13'd1;
		end else if (h_eff > HEIGHT_MAX) begin
			h_eff = HEIGHT_MAX;
		end
	end

	assign pos_col   = start_of_frame ? '0 : col_cnt_q;
	assign pos_row   = start_of_frame ? 12'd0 : row_cnt_q;
	assign has_right = (EW'(pos_col) + EW'(1)) < w_eff;
	assign last_row  = ({1'b0, pos_row} + 13'd1) >= h_eff;
	assign rd_addr   = cmd.accept ? pos_col : col_q + CW'(1);

	// luma: weighted sum of the three components
	assign luma_sum = 24'(KY_R * r_q) + 24'(KY_G * g_q) + 24'(KY_B * b_q);

	// chroma: scale the magnitude, then restore the sign
	assign du     = {1'b0, b_q} - {1'b0, y_q};
	assign dv     = {1'b0, r_q} - {1'b0, y_q};
	assign mag_u  = du[8] ? 8'(~du + 9'd1) : du[7:0];
	assign mag_v  = dv[8] ? 8'(~dv + 9'd1) : dv[7:0];
	assign prod_u = 24'(mag_u * KU);
	assign prod_v = 24'(mag_v * KV);
	assign u_val  = du[8] ? (~prod_u[23:16] + 8'd1) : prod_u[23:16];
	assign v_val  = dv[8] ? (~{1'b0, prod_v[23:16]} + 9'd1) : {1'b0, prod_v[23:16]};

	// line store
	always_ff @(posedge clk) begin
		if (cmd.commit) mem[col_q] <= cur_q;
		if (cmd.accept || cmd.luma) rd_q <= mem[rd_addr];
	end

	// item payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			r_q         <= red;
			g_q         <= green;
			b_q         <= blue;
			col_q       <= pos_col;
			row_q       <= pos_row;
			has_left_q  <= pos_col != '0;
			has_up_q    <= pos_row != 12'd0;
			has_right_q <= has_right;
			eof_q       <= !has_right && last_row;
		end
		if (cmd.luma) begin
			y_q  <= luma_sum[23:16];
			up_q <= rd_q;
		end
		if (cmd.chroma) begin
			ur_q  <= rd_q;
			cur_q <= '{y: y_q, u: u_val, v: v_val};
		end
		if (cmd.commit) begin
			column_q  <= 12'(col_q);
			row_out_q <= row_q;
			sl_q      <= has_left_q && is_similar(cur_q, left_q, cfg);
			sul_q     <= has_left_q && has_up_q && is_similar(cur_q, up_left_q, cfg);
			su_q      <= has_up_q && is_similar(cur_q, up_q, cfg);
			sur_q     <= has_up_q && has_right_q && is_similar(cur_q, ur_q, cfg);
			eof_out_q <= eof_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q   <= '0;
			row_cnt_q   <= 12'd0;
			left_q      <= '0;
			up_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (has_right) begin
					col_cnt_q <= pos_col + CW'(1);
					row_cnt_q <= pos_row;
				end else begin
					col_cnt_q <= '0;
					row_cnt_q <= last_row ? 12'd0 : pos_row + 12'd1;
				end
			end
			if (cmd.commit) begin
				left_q      <= cur_q;
				up_left_q   <= up_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free    = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign column          = column_q;
	assign row             = row_out_q;
	assign similar_left    = sl_q;
	assign similar_up_left = sul_q;
	assign similar_up      = su_q;
	assign similar_up_right = sur_q;
	assign end_of_frame    = eof_out_q;

endmodule

`default_nettype wire

[hw/rtl/pixel_yuv_similarity_edges_core.sv]
// ----------------------------------------------------------------------------
// pixel_yuv_similarity_edges_core
// Converts a raster stream of RGB pixels to YUV and reports, per pixel,
// similarity to the left, up-left, up and up-right neighbors.
// ----------------------------------------------------------------------------
// One pixel passes through acceptance, luma, chroma and commit, in that order.
// Its result beat is registered at the commit, and the next pixel can
// be accepted in the cycle after the commit. The line store has a single
// port and is read twice per pixel (up and up-right), and the conversion
// runs the luma and chroma multiplies in two steps.
// A result beat held by out_stall delays the next commit; the next pixel
// is still accepted while the previous result waits. The line store holds
// MAX_WIDTH entries and needs no clearing; rows are written before read.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_yuv_similarity_edges_core #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic        start_of_frame,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [11:0]      column,
	output logic [11:0]      row,
	output logic             similar_left,
	output logic             similar_up_left,
	output logic             similar_up,
	output logic             similar_up_right,
	output logic             end_of_frame
);
	import pyse_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{image_width: WIDTH_RST, image_height: HEIGHT_RST,
				luma_threshold: LUMA_RST, u_threshold: U_RST, v_threshold: V_RST};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data;
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data;
				REG_LUMA_THRESHOLD: cfg_q.luma_threshold <= cfg_data[7:0];
				REG_U_THRESHOLD:    cfg_q.u_threshold    <= cfg_data[7:0];
				REG_V_THRESHOLD:    cfg_q.v_threshold    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	pyse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pyse_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg              (cfg_q),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.start_of_frame   (start_of_frame),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.column           (column),
		.row              (row),
		.similar_left     (similar_left),
		.similar_up_left  (similar_up_left),
		.similar_up       (similar_up),
		.similar_up_right (similar_up_right),
		.end_of_frame     (end_of_frame)
	);

	// busy while a pixel is being converted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("pixel accepted while previous one in flight");

	// first row has no upper neighbors
	a_top_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row == 12'd0 |-> !similar_up && !similar_up_left && !similar_up_right)
		else $error("upper neighbor reported on first row");

	// last pixel of a frame closes its row
	a_eof_right: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> !similar_up_right)
		else $error("up-right neighbor reported at end of frame");

endmodule

`default_nettype wire
